// File: sv/gsh_pkg.sv
`timescale 1ns / 1ps
// Package: shared types, constants and arithmetic helpers of the signature hash.
package gsh_pkg;

   localparam logic [63:0] GEO_MAGIC  = 64'h0012_0090_0240_05A0;
   localparam logic [63:0] FNV_BASIS  = 64'hCBF2_9CE4_8422_2325;
   localparam logic [63:0] SALT_LEFT  = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [63:0] SALT_RIGHT = 64'h5555_5555_5555_5555;
   localparam logic [8:0]  FNV_LOW    = 9'd435;

   localparam logic [31:0] PARAM_MOD   = 32'd1000000;
   localparam logic [32:0] RECIP_PMOD  = 33'h0_431B_DE83;
   localparam logic [10:0] CYCLE       = 11'd1440;
   localparam logic [21:0] RECIP_CYCLE = 22'd2982616;
   localparam logic [9:0]  PERMUTE     = 10'd973;

   localparam int unsigned QSHIFT = 20;
   localparam logic [20:0] RECIP_12  = 21'((2 ** QSHIFT) / 12);
   localparam logic [20:0] RECIP_120 = 21'((2 ** QSHIFT) / 120);
   localparam logic [20:0] RECIP_144 = 21'((2 ** QSHIFT) / 144);
   localparam logic [20:0] RECIP_162 = 21'((2 ** QSHIFT) / 162);

   localparam logic [9:0] FIB [16] = '{10'd1, 10'd1, 10'd2, 10'd3, 10'd5, 10'd8, 10'd13,
      10'd21, 10'd34, 10'd55, 10'd89, 10'd144, 10'd233, 10'd377, 10'd610, 10'd987};

   typedef struct packed {
      logic [7:0]  beam_code;
      logic [3:0]  zone;
      logic [3:0]  position;
      logic [14:0] frame_slot;
      logic [6:0]  flower;
      logic [3:0]  texture;
      logic [3:0]  face;
      logic [6:0]  face_slot;
      logic [7:0]  ico_index;
      logic [3:0]  phase;
   } gsh_fields_type;

   typedef struct packed {
      logic [31:0]    item_index;
      gsh_fields_type fields;
   } gsh_entry_type;

   // h * (2^40 + 435)
   function automatic logic [63:0] mul_prime(input logic [63:0] h);
      logic [63:0] low;
      low = h * 64'(FNV_LOW);
      return (h << 40) + low;
   endfunction

   function automatic logic [63:0] rotl13(input logic [63:0] h);
      return {h[50:0], h[63:51]};
   endfunction

   // x / d for x < 2^11 by reciprocal multiply and one correction
   function automatic logic [10:0] quot11(input logic [10:0] x, input logic [20:0] m,
                                          input logic [10:0] d);
      logic [31:0] prod;
      logic [10:0] q;
      logic [21:0] r;
      prod = 32'(x) * 32'(m);
      q = prod[30:20];
      r = 22'(x) - 22'(q) * 22'(d);
      if (r >= 22'(d)) begin
         q = q + 11'd1;
      end
      return q;
   endfunction

endpackage

// File: sv/gsh_if.sv
`timescale 1ns / 1ps
// Interfaces: request and response channels with valid/ready handshake.
interface gsh_req_if;
   logic              valid;
   logic              ready;
   logic [31:0]       item_index;
   logic signed [7:0] item_weight;
   modport source (output valid, item_index, item_weight, input ready);
   modport sink   (input valid, item_index, item_weight, output ready);
endinterface

interface gsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  beam_code;
   logic [3:0]  zone;
   logic [3:0]  position;
   logic [14:0] frame_slot;
   logic [6:0]  flower;
   logic [3:0]  texture;
   logic [3:0]  face;
   logic [6:0]  face_slot;
   logic [7:0]  ico_index;
   logic [3:0]  phase;
   logic [63:0] pair_key;
   modport source (output valid, beam_code, zone, position, frame_slot, flower, texture,
                   face, face_slot, ico_index, phase, pair_key, input ready);
   modport sink   (input valid, beam_code, zone, position, frame_slot, flower, texture,
                   face, face_slot, ico_index, phase, pair_key, output ready);
endinterface

// File: sv/gsh_front.sv
`timescale 1ns / 1ps
// Front: accepts requests and derives the encoding fields in a seven-stage pipeline.
module gsh_front
   import gsh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   gsh_req_if.sink       req_ch,
   input  logic          queue_full,
   output logic          push,
   output gsh_entry_type push_data
);

   logic        adv;
   logic [6:0]  valid_ff;

   logic [31:0] idx1_ff, idx2_ff, idx3_ff, idx4_ff, idx5_ff, idx6_ff;
   logic [7:0]  code1_ff, code2_ff, code3_ff, code4_ff, code5_ff, code6_ff;
   logic [12:0] q1_ff, q1_in;
   logic [19:0] r2_ff, r2_in, r3_ff;
   logic [9:0]  qa3_ff, qa3_in;
   logic [10:0] enc4_ff, enc4_in;
   logic [20:0] p5_ff, p6_ff;
   logic [6:0]  d12_5_ff, d12_6_ff;
   logic [3:0]  r12_5_ff, r12_6_ff;
   logic [3:0]  face5_ff, face6_ff;
   logic [6:0]  fslot5_ff, fslot6_ff;
   logic [7:0]  ico5_ff, ico6_ff;
   logic [3:0]  tex5_ff, tex6_ff;
   logic [9:0]  pq6_ff, pq6_in;
   logic [3:0]  phase6_ff, phase6_in;
   gsh_entry_type entry7_ff, entry7_in;

   logic [10:0] d12_in, d120_in, d144_in, d162_in, d12b;
   logic [63:0] prod1, prod3, prod6;
   logic [19:0] t4;
   logic [20:0] pipe_t;
   logic [10:0] pipe7;

   assign adv          = !(valid_ff[6] && queue_full);
   assign req_ch.ready = adv;
   assign push         = valid_ff[6] && !queue_full;
   assign push_data    = entry7_ff;

   always_comb begin
      prod1 = 64'(req_ch.item_index) * 64'(RECIP_PMOD);
      q1_in = prod1[62:50];
      r2_in = 20'(idx1_ff - 32'(q1_ff) * PARAM_MOD);
      prod3 = 64'(r2_ff) * 64'(RECIP_CYCLE);
      qa3_in = prod3[41:32];
      t4 = r3_ff - 20'(qa3_ff) * 20'(CYCLE);
      if (t4 >= 20'(CYCLE)) begin
         enc4_in = 11'(t4 - 20'(CYCLE));
      end else begin
         enc4_in = 11'(t4);
      end
      d12_in  = quot11(enc4_ff, RECIP_12, 11'd12);
      d120_in = quot11(enc4_ff, RECIP_120, 11'd120);
      d144_in = quot11(enc4_ff, RECIP_144, 11'd144);
      d162_in = quot11(enc4_ff, RECIP_162, 11'd162);
      prod6  = 64'(p5_ff) * 64'(RECIP_CYCLE);
      pq6_in = prod6[41:32];
      d12b   = quot11(11'(d12_5_ff), RECIP_12, 11'd12);
      phase6_in = 4'(11'(d12_5_ff) - d12b * 11'd12);
      pipe_t = p6_ff - 21'(pq6_ff) * 21'(CYCLE);
      if (pipe_t >= 21'(CYCLE)) begin
         pipe7 = 11'(pipe_t - 21'(CYCLE));
      end else begin
         pipe7 = 11'(pipe_t);
      end
      entry7_in.item_index        = idx6_ff;
      entry7_in.fields.beam_code  = code6_ff;
      entry7_in.fields.zone       = code6_ff[7:4];
      entry7_in.fields.position   = code6_ff[3:0];
      entry7_in.fields.frame_slot = 15'(pipe7) * 15'd12 + 15'(r12_6_ff);
      entry7_in.fields.flower     = d12_6_ff;
      entry7_in.fields.texture    = tex6_ff;
      entry7_in.fields.face       = face6_ff;
      entry7_in.fields.face_slot  = fslot6_ff;
      entry7_in.fields.ico_index  = ico6_ff;
      entry7_in.fields.phase      = phase6_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[5:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx1_ff  <= req_ch.item_index;
         code1_ff <= 8'(req_ch.item_weight) ^ 8'h80;
         q1_ff    <= q1_in;
         idx2_ff  <= idx1_ff;
         code2_ff <= code1_ff;
         r2_ff    <= r2_in;
         idx3_ff  <= idx2_ff;
         code3_ff <= code2_ff;
         r3_ff    <= r2_ff;
         qa3_ff   <= qa3_in;
         idx4_ff  <= idx3_ff;
         code4_ff <= code3_ff;
         enc4_ff  <= enc4_in;
         idx5_ff  <= idx4_ff;
         code5_ff <= code4_ff;
         p5_ff     <= 21'(enc4_ff) * 21'(PERMUTE);
         d12_5_ff  <= 7'(d12_in);
         r12_5_ff  <= 4'(enc4_ff - d12_in * 11'd12);
         face5_ff  <= 4'(d120_in);
         fslot5_ff <= 7'(enc4_ff - d120_in * 11'd120);
         ico5_ff   <= 8'(enc4_ff - d162_in * 11'd162);
         tex5_ff   <= 4'(d144_in);
         idx6_ff   <= idx5_ff;
         code6_ff  <= code5_ff;
         p6_ff     <= p5_ff;
         pq6_ff    <= pq6_in;
         d12_6_ff  <= d12_5_ff;
         r12_6_ff  <= r12_5_ff;
         face6_ff  <= face5_ff;
         fslot6_ff <= fslot5_ff;
         ico6_ff   <= ico5_ff;
         tex6_ff   <= tex5_ff;
         phase6_ff <= phase6_in;
         entry7_ff <= entry7_in;
      end
   end

endmodule

// File: sv/gsh_queue.sv
`timescale 1ns / 1ps
// Queue: small register FIFO between front and back.
module gsh_queue
   import gsh_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  gsh_entry_type push_data,
   input  logic          pop,
   output gsh_entry_type head,
   output logic          full,
   output logic          empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   gsh_entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("transfer into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CW'(1))
      else $error("queue count did not follow push");
`endif

endmodule

// File: sv/gsh_hash_core.sv
`timescale 1ns / 1ps
// Hash core: thirteen-stage pipelined geometric hash of a 64-bit seed.
module gsh_hash_core
   import gsh_pkg::*;
#(
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [63:0]       seed,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [63:0]       hash,
   output logic [SIDE_W-1:0] side_out
);

   localparam int NS = 13;

   logic [NS-1:0]     valid_ff;
   logic [63:0]       h_ff [NS];
   logic [63:0]       h_in [NS];
   logic [63:0]       seed_ff [NS];
   logic [63:0]       seed_in [NS];
   logic [SIDE_W-1:0] side_ff [NS];
   logic [SIDE_W-1:0] side_pin [NS];
   logic [63:0]       plo_ff [8];
   logic [63:0]       plo_in [8];
   logic [63:0]       phi_ff [8];
   logic [63:0]       phi_in [8];
   logic [63:0]       acc9, acc10;

   always_comb begin
      seed_in[0]  = seed;
      side_pin[0] = side_in;
      for (int s = 1; s < NS; s++) begin
         seed_in[s]  = seed_ff[s-1];
         side_pin[s] = side_ff[s-1];
      end
      h_in[0] = mul_prime(FNV_BASIS ^ 64'(seed[7:0]));
      for (int k = 1; k < 8; k++) begin
         h_in[k] = mul_prime(h_ff[k-1] ^ 64'(seed_ff[k-1][8*k +: 8]));
      end
      h_in[8] = h_ff[7];
      for (int j = 0; j < 8; j++) begin
         plo_in[j] = 64'(FIB[j]) * (seed_ff[7] >> j);
         phi_in[j] = 64'(FIB[j+8]) * (seed_ff[8] >> j);
      end
      acc9 = h_ff[8];
      for (int j = 0; j < 8; j++) begin
         acc9 = rotl13(acc9 ^ plo_ff[j]);
      end
      h_in[9] = acc9;
      acc10 = h_ff[9];
      for (int j = 0; j < 8; j++) begin
         acc10 = rotl13(acc10 ^ phi_ff[j]);
      end
      h_in[10] = acc10;
      h_in[11] = mul_prime(h_ff[10] ^ GEO_MAGIC);
      h_in[12] = h_ff[11] ^ (h_ff[11] >> 33);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NS; s++) begin
            h_ff[s]    <= h_in[s];
            seed_ff[s] <= seed_in[s];
            side_ff[s] <= side_pin[s];
         end
         for (int j = 0; j < 8; j++) begin
            plo_ff[j] <= plo_in[j];
            phi_ff[j] <= phi_in[j];
         end
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign hash      = h_ff[NS-1];
   assign side_out  = side_ff[NS-1];

endmodule

// File: sv/gsh_back.sv
`timescale 1ns / 1ps
// Back: chained hash cores for the bond key and the response register.
module gsh_back
   import gsh_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          empty,
   input  gsh_entry_type head,
   output logic          pop,
   gsh_rsp_if.source     rsp_ch
);

   localparam int FW = $bits(gsh_fields_type);

   logic           en;
   logic           v1, v2;
   logic [63:0]    g, hl, hr;
   gsh_fields_type f1, f2;
   logic           rsp_valid_ff;
   gsh_fields_type rsp_fields_ff;
   logic [63:0]    rsp_key_ff;

   assign en  = !rsp_valid_ff || rsp_ch.ready;
   assign pop = en && !empty;

   gsh_hash_core #(.SIDE_W(FW)) u_seed_hash (
      .clock(clock), .reset(reset), .en(en), .in_valid(pop),
      .seed({32'd0, head.item_index}), .side_in(head.fields),
      .out_valid(v1), .hash(g), .side_out(f1)
   );

   gsh_hash_core #(.SIDE_W(FW)) u_left_hash (
      .clock(clock), .reset(reset), .en(en), .in_valid(v1),
      .seed(g ^ SALT_LEFT), .side_in(f1),
      .out_valid(v2), .hash(hl), .side_out(f2)
   );

   gsh_hash_core #(.SIDE_W(1)) u_right_hash (
      .clock(clock), .reset(reset), .en(en), .in_valid(v1),
      .seed(g ^ SALT_RIGHT), .side_in(1'b0),
      .out_valid(), .hash(hr), .side_out()
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v2;
      end
   end

   always_ff @(posedge clock) begin
      if (en && v2) begin
         rsp_fields_ff <= f2;
         rsp_key_ff    <= hl ^ hr;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.beam_code  = rsp_fields_ff.beam_code;
   assign rsp_ch.zone       = rsp_fields_ff.zone;
   assign rsp_ch.position   = rsp_fields_ff.position;
   assign rsp_ch.frame_slot = rsp_fields_ff.frame_slot;
   assign rsp_ch.flower     = rsp_fields_ff.flower;
   assign rsp_ch.texture    = rsp_fields_ff.texture;
   assign rsp_ch.face       = rsp_fields_ff.face;
   assign rsp_ch.face_slot  = rsp_fields_ff.face_slot;
   assign rsp_ch.ico_index  = rsp_fields_ff.ico_index;
   assign rsp_ch.phase      = rsp_fields_ff.phase;
   assign rsp_ch.pair_key   = rsp_key_ff;

endmodule

// File: sv/geometric_signature_hash.sv
`timescale 1ns / 1ps
// Top level: geometric signature hash, front pipeline, queue and hash back end.
// From request transfer to response valid, with no stalls, an item passes 7 front stages,
// the queue, two 13-stage hash cores in series and 1 output register.
// Throughput: one item per cycle when nothing stalls; the front and back stall independently via the queue.
// Reset clears all valid bits and the queue pointers and count; the data registers are not reset.
module geometric_signature_hash
   import gsh_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   gsh_req_if.sink   req_ch,
   gsh_rsp_if.source rsp_ch
);

   logic          push, pop, full, empty;
   gsh_entry_type push_data, head;

   gsh_front u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch), .queue_full(full),
      .push(push), .push_data(push_data)
   );

   gsh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .pop(pop), .head(head), .full(full), .empty(empty)
   );

   gsh_back u_back (
      .clock(clock), .reset(reset), .empty(empty), .head(head), .pop(pop),
      .rsp_ch(rsp_ch)
   );

endmodule
